/* sv/idc_pkg.sv */
// ----------------------------------------------------------------------------
// idc_pkg: shared types and codes of the indexed circular deque
// Field widths, command and status codes, and the command and result beats
// that travel between the front part, the queues and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package idc_pkg;

	localparam int OP_W  = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 4;
	localparam int ST_W  = 3;
	localparam int OCC_W = 5;

	// op field encoding
	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_ERASE     = 3'd2;
	localparam logic [OP_W-1:0] OP_READ      = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND      = 3'd4;

	// status field encoding
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

	typedef enum logic [2:0] {
		KIND_NOP,
		KIND_INS_FRONT,
		KIND_INS_BACK,
		KIND_ERASE,
		KIND_READ,
		KIND_FIND
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [VAL_W-1:0]  value;
		logic [POS_W-1:0]         position;
	} cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [VAL_W-1:0]  read_value;
		logic [POS_W-1:0]         found_position;
		logic [OCC_W-1:0]         occupancy;
	} res_t;

endpackage

`default_nettype wire

/* sv/idc_fifo.sv */
// ----------------------------------------------------------------------------
// idc_fifo: two-entry queue
// Holds up to two beats; decouples the producer and consumer sides.
// ----------------------------------------------------------------------------
`default_nettype none

module idc_fifo #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] store_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = store_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) store_q[wr_q] <= din;
	end

endmodule

`default_nettype wire

/* sv/idc_front.sv */
// ----------------------------------------------------------------------------
// idc_front: command intake
// Takes input beats, decodes the op field into a command kind and hands the
// command to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module idc_front (
	input  logic                       push,
	output logic                       full,
	input  logic [idc_pkg::OP_W-1:0]   op,
	input  logic signed [idc_pkg::VAL_W-1:0] value,
	input  logic [idc_pkg::POS_W-1:0]  position,
	output logic                       cq_push,
	output idc_pkg::cmd_t              cmd,
	input  logic                       cq_full
);

	import idc_pkg::*;

	kind_t kind;

	// unused op codes become a no-op that still returns one result
	always_comb begin
		unique case (op)
			OP_INS_FRONT: kind = KIND_INS_FRONT;
			OP_INS_BACK:  kind = KIND_INS_BACK;
			OP_ERASE:     kind = KIND_ERASE;
			OP_READ:      kind = KIND_READ;
			OP_FIND:      kind = KIND_FIND;
			default:      kind = KIND_NOP;
		endcase
	end

	assign cmd.kind     = kind;
	assign cmd.value    = value;
	assign cmd.position = position;
	assign cq_push      = push && !cq_full;
	assign full         = cq_full;

endmodule

`default_nettype wire

/* sv/idc_back.sv */
// ----------------------------------------------------------------------------
// idc_back: deque store and command sequencer
// Owns the ring memory, head slot and count; carries out one command at a
// time, walking the ring one slot a cycle for erase and find.
// ----------------------------------------------------------------------------
`default_nettype none

module idc_back #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cq_empty,
	output logic          cq_pop,
	input  idc_pkg::cmd_t cmd,
	input  logic          rq_full,
	output logic          rq_push,
	output idc_pkg::res_t res
);

	import idc_pkg::*;

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int PCW = (CW > POS_W) ? CW : POS_W;
	localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
	localparam logic [AW:0]   RING_SIZE  = (AW + 1)'(DEPTH);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_RDWAIT = 5'b00010,
		S_ERASE  = 5'b00100,
		S_FIND   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
		return (s == '0) ? LAST_SLOT : s - 1'b1;
	endfunction

	// head + logical, logical below DEPTH: one conditional subtract
	function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] h,
			input logic [CW-1:0] logical);
		logic [AW:0] sum;
		sum = {1'b0, h} + (AW + 1)'(logical);
		if (sum >= RING_SIZE) sum = sum - RING_SIZE;
		return sum[AW-1:0];
	endfunction

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	state_t             state_q, state_d;
	logic [AW-1:0]      head_q, head_d;
	logic [CW-1:0]      count_q, count_d;
	logic [AW-1:0]      rslot_q, rslot_d;
	logic [AW-1:0]      wslot_q, wslot_d;
	logic [CW-1:0]      rem_q, rem_d;
	logic [AW-1:0]      idx_q, idx_d;
	logic [VAL_W-1:0]   val_q, val_d;
	logic [ST_W-1:0]    st_q, st_d;
	logic [VAL_W-1:0]   rd_q, rd_d;
	logic [POS_W-1:0]   fpos_q, fpos_d;

	logic               we;
	logic [AW-1:0]      waddr;
	logic [VAL_W-1:0]   wdata;
	logic [AW-1:0]      raddr;

	logic [CW-1:0]      pos_c;
	logic               pos_ok;

	assign pos_c  = CW'(cmd.position);
	assign pos_ok = PCW'(cmd.position) < PCW'(count_q);

	always_comb begin
		logic [AW-1:0] first_slot;
		logic [CW-1:0] moves;
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		rslot_d    = rslot_q;
		wslot_d    = wslot_q;
		rem_d      = rem_q;
		idx_d      = idx_q;
		val_d      = val_q;
		st_d       = st_q;
		rd_d       = rd_q;
		fpos_d     = fpos_q;
		we         = 1'b0;
		waddr      = head_q;
		wdata      = cmd.value;
		raddr      = head_q;
		cq_pop     = 1'b0;
		rq_push    = 1'b0;
		first_slot = slot_at(head_q, pos_c);
		moves      = count_q - CW'(1) - pos_c;

		unique case (state_q)
			S_IDLE: begin
				if (!cq_empty) begin
					cq_pop  = 1'b1;
					st_d    = ST_OK;
					rd_d    = '0;
					fpos_d  = '0;
					state_d = S_DONE;
					unique case (cmd.kind)
						KIND_INS_FRONT: begin
							if (count_q == FULL_COUNT) begin
								st_d = ST_FULL;
							end else begin
								head_d  = slot_dec(head_q);
								we      = 1'b1;
								waddr   = slot_dec(head_q);
								count_d = count_q + 1'b1;
							end
						end
						KIND_INS_BACK: begin
							if (count_q == FULL_COUNT) begin
								st_d = ST_FULL;
							end else begin
								we      = 1'b1;
								waddr   = slot_at(head_q, count_q);
								count_d = count_q + 1'b1;
							end
						end
						KIND_ERASE: begin
							if (count_q == '0) begin
								st_d = ST_EMPTY;
							end else if (!pos_ok) begin
								st_d = ST_RANGE;
							end else if (moves == '0) begin
								count_d = count_q - 1'b1;
							end else begin
								wslot_d = first_slot;
								rslot_d = slot_inc(first_slot);
								raddr   = slot_inc(first_slot);
								rem_d   = moves;
								state_d = S_ERASE;
							end
						end
						KIND_READ: begin
							if (count_q == '0) begin
								st_d = ST_EMPTY;
							end else if (!pos_ok) begin
								st_d = ST_RANGE;
							end else begin
								raddr   = first_slot;
								state_d = S_RDWAIT;
							end
						end
						KIND_FIND: begin
							if (count_q == '0) begin
								st_d = ST_EMPTY;
							end else begin
								raddr   = head_q;
								rslot_d = head_q;
								idx_d   = '0;
								val_d   = cmd.value;
								state_d = S_FIND;
							end
						end
						default: st_d = ST_OK;
					endcase
				end
			end
			S_RDWAIT: begin
				rd_d    = rdata_q;
				state_d = S_DONE;
			end
			S_ERASE: begin
				// rdata holds the entry one place after the write slot
				we    = 1'b1;
				waddr = wslot_q;
				wdata = rdata_q;
				if (rem_q == CW'(1)) begin
					count_d = count_q - 1'b1;
					state_d = S_DONE;
				end else begin
					raddr   = slot_inc(rslot_q);
					rslot_d = slot_inc(rslot_q);
					wslot_d = rslot_q;
					rem_d   = rem_q - 1'b1;
				end
			end
			S_FIND: begin
				if (rdata_q == val_q) begin
					fpos_d  = POS_W'(idx_q);
					state_d = S_DONE;
				end else if (CW'(idx_q) + CW'(1) == count_q) begin
					st_d    = ST_NOTFOUND;
					state_d = S_DONE;
				end else begin
					raddr   = slot_inc(rslot_q);
					rslot_d = slot_inc(rslot_q);
					idx_d   = idx_q + 1'b1;
				end
			end
			S_DONE: begin
				if (!rq_full) begin
					rq_push = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		rslot_q <= rslot_d;
		wslot_q <= wslot_d;
		rem_q   <= rem_d;
		idx_q   <= idx_d;
		val_q   <= val_d;
		st_q    <= st_d;
		rd_q    <= rd_d;
		fpos_q  <= fpos_d;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign res.status         = st_q;
	assign res.read_value     = rd_q;
	assign res.found_position = fpos_q;
	assign res.occupancy      = OCC_W'(count_q);

endmodule

`default_nettype wire

/* sv/indexed_circular_deque_top.sv */
// ----------------------------------------------------------------------------
// indexed_circular_deque_top: indexed circular deque
// Fixed-capacity double-ended store of signed 32-bit values with insert at
// either end, erase and read by position, and find by value.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | beat fields
//  ----------+--------------------+---------------------------------------------
//  command   | push / full        | op, value, position
//  result    | pop / empty        | status, read_value, found_position, occupancy
//
// The front decodes each command beat into a two-entry command queue; the
// back executes one command at a time and posts a result into a two-entry
// result queue, so a stall on either side is absorbed until the queues fill.
// Insert, spare op or refused command: idle straight to done; read adds a
// read-wait state; erase moves count - 1 - position entries in the erase
// state; find compares from the head in the find state until a match or the
// last entry. Each command passes through the command queue, the back and
// the result queue; a full result queue holds the back until a slot frees.
// Reset (arst_n low) empties both queues and the deque at once; ring
// contents are not cleared and never used before being written.
//
`default_nettype none

module indexed_circular_deque_top #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [idc_pkg::OP_W-1:0]          op,
	input  logic signed [idc_pkg::VAL_W-1:0]  value,
	input  logic [idc_pkg::POS_W-1:0]         position,
	output logic                              empty,
	input  logic                              pop,
	output logic [idc_pkg::ST_W-1:0]          status,
	output logic signed [idc_pkg::VAL_W-1:0]  read_value,
	output logic [idc_pkg::POS_W-1:0]         found_position,
	output logic [idc_pkg::OCC_W-1:0]         occupancy
);

	import idc_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);

	// command path
	cmd_t             cmd_in;
	cmd_t             cmd_out;
	logic [CMD_W-1:0] cq_dout;
	logic             cq_push;
	logic             cq_full;
	logic             cq_pop;
	logic             cq_empty;

	// result path
	res_t             res_in;
	res_t             res_out;
	logic [RES_W-1:0] rq_dout;
	logic             rq_push;
	logic             rq_full;

	idc_front u_front (
		.push     (push),
		.full     (full),
		.op       (op),
		.value    (value),
		.position (position),
		.cq_push  (cq_push),
		.cmd      (cmd_in),
		.cq_full  (cq_full)
	);

	idc_fifo #(
		.WIDTH (CMD_W)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.din    (cmd_in),
		.full   (cq_full),
		.pop    (cq_pop),
		.dout   (cq_dout),
		.empty  (cq_empty)
	);

	assign cmd_out = cq_dout;

	idc_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_empty (cq_empty),
		.cq_pop   (cq_pop),
		.cmd      (cmd_out),
		.rq_full  (rq_full),
		.rq_push  (rq_push),
		.res      (res_in)
	);

	idc_fifo #(
		.WIDTH (RES_W)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (res_in),
		.full   (rq_full),
		.pop    (pop),
		.dout   (rq_dout),
		.empty  (empty)
	);

	assign res_out        = rq_dout;
	assign status         = res_out.status;
	assign read_value     = res_out.read_value;
	assign found_position = res_out.found_position;
	assign occupancy      = res_out.occupancy;

	// back never posts into a full result queue
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rq_push |-> !rq_full)
		else $error("result posted into full queue");

	// back only takes a command that is present
	a_no_cmd_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !cq_empty)
		else $error("command taken from empty queue");

	// a taken command leaves the back busy, so it never takes two commands in a row
	a_back_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |=> !cq_pop)
		else $error("back took two commands in a row");

	// failed commands carry zero read value and found position
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (read_value == '0 && found_position == '0))
		else $error("nonzero payload on failed command");

endmodule

`default_nettype wire

/* dv/tb_indexed_circular_deque_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_circular_deque_top: self-checking bench for the indexed deque
// A short table of directed commands walks the empty and full corners, then
// phased random traffic runs with random stalls on both sides. Result beats
// are checked field by field against typed-in wants or a shadow deque.
// ----------------------------------------------------------------------------

module tb_indexed_circular_deque_top;

	import idc_pkg::*;

	localparam int DEPTH = 16;

	// op codes the block ignores
	localparam logic [OP_W-1:0] OP_NOP_A = 3'd5;
	localparam logic [OP_W-1:0] OP_NOP_B = 3'd6;
	localparam logic [OP_W-1:0] OP_NOP_C = 3'd7;

	localparam int N_RANDOM    = 1500; // counted commands in the random part
	localparam int CALM_TAIL   = 150;  // last commands run with no stalls
	localparam int HOLD_AT     = 300;  // receiver long hold-off starts here
	localparam int DRAIN_AT    = 700;  // sender waits for all results here
	localparam int HOLD_CYCLES = 120;
	localparam int SETTLE      = 40;   // > worst back time + queue latency

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     push     = 1'b0;
	logic                     full;
	logic [OP_W-1:0]          op       = '0;
	logic signed [VAL_W-1:0]  value    = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     empty;
	logic                     pop      = 1'b0;
	logic [ST_W-1:0]          status;
	logic signed [VAL_W-1:0]  read_value;
	logic [POS_W-1:0]         found_position;
	logic [OCC_W-1:0]         occupancy;

	// typed-in expectation travelling with the command beat (directed rows)
	bit   beat_known = 1'b0;
	res_t beat_want  = '0;

	// shadow deque, updated when a command beat is accepted
	logic signed [VAL_W-1:0] shadow_slots [DEPTH];
	int                      shadow_head  = 0;
	int                      shadow_count = 0;

	res_t pending_results [$];
	int   errors    = 0;
	bit   calm      = 1'b0;
	bit   hold_req  = 1'b0;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] position;
		int               reps;   // row repeats with value + k
		bit               known;  // want below is valid (single rows only)
		res_t             want;
	} plan_row_t;

	plan_row_t plan [$];

	indexed_circular_deque_top #(
		.DEPTH(DEPTH)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.op            (op),
		.value         (value),
		.position      (position),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.read_value    (read_value),
		.found_position(found_position),
		.occupancy     (occupancy)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Apply one command to the shadow deque; returns the result it should give.
	// Positions are logical (from the front); the ring wraps at DEPTH.
	function automatic res_t deque_apply(input logic [OP_W-1:0] o,
	                                     input logic signed [VAL_W-1:0] v,
	                                     input logic [POS_W-1:0] p);
		res_t r;
		int   i;
		bit   hit;
		r = '0;
		r.status = ST_OK;
		case (o)
			OP_INS_FRONT: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_slots[shadow_head] = v;
					shadow_count++;
				end
			end
			OP_INS_BACK: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_slots[(shadow_head + shadow_count) % DEPTH] = v;
					shadow_count++;
				end
			end
			OP_ERASE: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else if (p >= shadow_count) begin
					r.status = ST_RANGE;
				end else begin
					// later entries slide toward the front to close the gap
					for (i = p; i + 1 < shadow_count; i++)
						shadow_slots[(shadow_head + i) % DEPTH] =
							shadow_slots[(shadow_head + i + 1) % DEPTH];
					shadow_count--;
				end
			end
			OP_READ: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
				else if (p >= shadow_count)
					r.status = ST_RANGE;
				else
					r.read_value = shadow_slots[(shadow_head + p) % DEPTH];
			end
			OP_FIND: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					hit = 1'b0;
					for (i = 0; i < shadow_count && !hit; i++) begin
						if (shadow_slots[(shadow_head + i) % DEPTH] == v) begin
							hit = 1'b1;
							r.found_position = POS_W'(i);
						end
					end
					if (!hit)
						r.status = ST_NOTFOUND;
				end
			end
			default: ; // spare codes: no effect, status ok
		endcase
		r.occupancy = OCC_W'(shadow_count);
		return r;
	endfunction

	task automatic add_row(input logic [OP_W-1:0] o, input logic [VAL_W-1:0] v,
	                       input logic [POS_W-1:0] p, input int reps, input bit known,
	                       input logic [ST_W-1:0] st, input logic [VAL_W-1:0] rd,
	                       input logic [POS_W-1:0] fp, input logic [OCC_W-1:0] occ);
		plan_row_t row;
		row.op       = o;
		row.value    = v;
		row.position = p;
		row.reps     = reps;
		row.known    = known;
		row.want     = '{status: st, read_value: rd, found_position: fp, occupancy: occ};
		plan.push_back(row);
	endtask

	// Offer one command beat and hold it until the block takes it.
	task automatic offer(input logic [OP_W-1:0] o, input logic [VAL_W-1:0] v,
	                     input logic [POS_W-1:0] p, input bit known, input res_t w);
		push       <= 1'b1;
		op         <= o;
		value      <= v;
		position   <= p;
		beat_known <= known;
		beat_want  <= w;
		do @(posedge clk); while (full);
	endtask

	// Beat monitor: predict on accepted commands, check on accepted results.
	// Both handshakes are sampled at the edge, before any driver update lands.
	always @(posedge clk) begin
		res_t predicted;
		res_t want;
		if (arst_n) begin
			if (push && !full) begin
				predicted = deque_apply(op, value, position);
				pending_results.push_back(beat_known ? beat_want : predicted);
			end
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result beat with nothing expected: st=%0d rd=%0d fp=%0d occ=%0d",
						         $time, status, read_value, found_position, occupancy);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status || read_value !== want.read_value ||
					    found_position !== want.found_position ||
					    occupancy !== want.occupancy) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch exp st=%0d rd=%0d fp=%0d occ=%0d got st=%0d rd=%0d fp=%0d occ=%0d",
							         $time, want.status, want.read_value, want.found_position,
							         want.occupancy, status, read_value, found_position, occupancy);
					end
				end
			end
		end
	end

	// Result side: random pop bursts and stalls, one long hold-off on request,
	// and a steady pop during the calm tail.
	initial begin : result_side
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 25) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Command side: directed table, then phased random traffic.
	initial begin : command_side
		int               n;
		int               k;
		int               mode;
		int               mode_left;
		int               r;
		bit               hold_fired;
		bit               drain_fired;
		logic [OP_W-1:0]  pick_op;
		logic [VAL_W-1:0] pick_val;
		logic [POS_W-1:0] pick_pos;

		// empty store: every access is refused, spare codes do nothing
		add_row(OP_READ,      '0,           0,  1, 1, ST_EMPTY,    '0, 0, 0);
		add_row(OP_ERASE,     '0,           15, 1, 1, ST_EMPTY,    '0, 0, 0);
		add_row(OP_FIND,      32'h8000_0000, 0, 1, 1, ST_EMPTY,    '0, 0, 0);
		add_row(OP_NOP_A,     32'hFFFF_FFFF, 15, 1, 1, ST_OK,      '0, 0, 0);
		add_row(OP_NOP_C,     '0,           0,  1, 1, ST_OK,       '0, 0, 0);
		// value extremes at both ends
		add_row(OP_INS_BACK,  32'h7FFF_FFFF, 0, 1, 1, ST_OK,       '0, 0, 1);
		add_row(OP_INS_FRONT, 32'h8000_0000, 0, 1, 1, ST_OK,       '0, 0, 2);
		add_row(OP_READ,      '0,           0,  1, 1, ST_OK, 32'h8000_0000, 0, 2);
		add_row(OP_READ,      '0,           1,  1, 1, ST_OK, 32'h7FFF_FFFF, 0, 2);
		// position at the count and at the field maximum
		add_row(OP_READ,      '0,           2,  1, 1, ST_RANGE,    '0, 0, 2);
		add_row(OP_ERASE,     '0,           15, 1, 1, ST_RANGE,    '0, 0, 2);
		add_row(OP_FIND,      32'h7FFF_FFFF, 0, 1, 1, ST_OK,       '0, 1, 2);
		add_row(OP_FIND,      '0,           0,  1, 1, ST_NOTFOUND, '0, 0, 2);
		// fill from the front, then a back insert wraps the ring past the last slot
		add_row(OP_INS_FRONT, 32'd100,      0,  13, 0, ST_OK,      '0, 0, 0);
		add_row(OP_INS_BACK,  32'hFFFF_FFFF, 0, 1, 1, ST_OK,       '0, 0, 16);
		// full store: both inserts refused
		add_row(OP_INS_FRONT, 32'd5,        0,  1, 1, ST_FULL,     '0, 0, 16);
		add_row(OP_INS_BACK,  32'd5,        0,  1, 1, ST_FULL,     '0, 0, 16);
		add_row(OP_FIND,      32'hFFFF_FFFF, 0, 1, 1, ST_OK,       '0, 15, 16);
		add_row(OP_READ,      '0,           15, 1, 1, ST_OK, 32'hFFFF_FFFF, 0, 16);
		// erase at the front moves all later entries, at the back moves none
		add_row(OP_ERASE,     '0,           0,  1, 1, ST_OK,       '0, 0, 15);
		add_row(OP_ERASE,     '0,           14, 1, 1, ST_OK,       '0, 0, 14);
		add_row(OP_ERASE,     '0,           7,  1, 0, ST_OK,       '0, 0, 0);
		add_row(OP_FIND,      32'd106,      0,  1, 0, ST_OK,       '0, 0, 0);
		add_row(OP_ERASE,     '0,           0,  13, 0, ST_OK,      '0, 0, 0);
		add_row(OP_NOP_B,     32'h5555_AAAA, 10, 1, 1, ST_OK,      '0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			for (k = 0; k < plan[i].reps; k++)
				offer(plan[i].op, plan[i].value + k, plan[i].position,
				      plan[i].known && plan[i].reps == 1, plan[i].want);
		end

		// Random part in phases: fill-leaning, drain-leaning and even mixes,
		// so the store swings between empty and full many times.
		n           = 0;
		mode        = 0;
		mode_left   = 0;
		hold_fired  = 1'b0;
		drain_fired = 1'b0;
		while (n < N_RANDOM) begin
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 60);
			end
			mode_left--;

			if (n >= HOLD_AT && !hold_fired) begin
				// receiver stops; keep offering so both queues back up
				hold_fired = 1'b1;
				hold_req   = 1'b1;
			end
			if (n >= DRAIN_AT && !drain_fired) begin
				drain_fired = 1'b1;
				push <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end

			calm = (n >= N_RANDOM - CALM_TAIL);
			if (!calm && $urandom_range(0, 99) < 15) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end

			r = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 3)
				pick_op = OP_W'($urandom_range(int'(OP_NOP_A), int'(OP_NOP_C)));
			else if (mode == 0)
				pick_op = r < 40 ? OP_INS_FRONT : r < 75 ? OP_INS_BACK :
				          r < 82 ? OP_ERASE : r < 91 ? OP_READ : OP_FIND;
			else if (mode == 1)
				pick_op = r < 12 ? OP_INS_FRONT : r < 24 ? OP_INS_BACK :
				          r < 70 ? OP_ERASE : r < 85 ? OP_READ : OP_FIND;
			else
				pick_op = r < 20 ? OP_INS_FRONT : r < 40 ? OP_INS_BACK :
				          r < 60 ? OP_ERASE : r < 80 ? OP_READ : OP_FIND;

			// small values repeat often, so find has to pick the first match
			r = $urandom_range(0, 9);
			if (r < 3)
				pick_val = $urandom_range(0, 7);
			else if (r == 3)
				pick_val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			else
				pick_val = $urandom;
			if (pick_op == OP_FIND && shadow_count > 0 && $urandom_range(0, 99) < 60)
				pick_val = shadow_slots[(shadow_head +
				            $urandom_range(0, shadow_count - 1)) % DEPTH];

			// mostly in range; the rest anywhere in the field
			if (shadow_count > 0 && $urandom_range(0, 99) < 80)
				pick_pos = POS_W'($urandom_range(0, shadow_count - 1));
			else
				pick_pos = POS_W'($urandom_range(0, 15));

			offer(pick_op, pick_val, pick_pos, 1'b0, '0);
			if (pick_op <= OP_FIND)
				n++;
		end
		push <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
